// ----- hdl/obes_pkg.sv -----
// ----------------------------------------------------------------------------
// obes_pkg
// Shared types and constants for the occupied bandwidth energy search.
// ----------------------------------------------------------------------------
`default_nettype none

package obes_pkg;

    // fixed field widths
    localparam int CARRIER_W = 9;
    localparam int THRESH_W  = 7;
    localparam int HALF_W    = 10;
    localparam int BW_W      = 11;
    localparam int ENERGY_W  = 41;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = CARRIER_W;

    localparam logic [CFG_IDX_W-1:0] REG_CARRIER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 1'd1;

    localparam logic [CARRIER_W-1:0] CARRIER_RST = 9'd50;
    localparam logic [THRESH_W-1:0]  THRESH_RST  = 7'd80;

    // parameter defaults
    localparam int DEF_MAX_BINS  = 512;
    localparam int DEF_MAG_WIDTH = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_PROD,
        ST_CTR_RD,
        ST_CTR_ADD,
        ST_STEP_RD,
        ST_ADD_LO,
        ST_ADD_HI,
        ST_SCALE,
        ST_CMP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;     // item accepted
        logic init;     // start of search
        logic prod;     // one bit of threshold * total
        logic rd_ctr;   // read carrier bin
        logic rd_step;  // widen window, read both edges
        logic add_lo;
        logic add_hi;
        logic scale;    // window * 100
        logic cmp;      // evaluate stop conditions
        logic clear;    // spectrum done
    } t_dp_cmd;

    typedef struct packed {
        logic prod_done;
        logic hit;
        logic at_edge;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- hdl/obes_ctrl.sv -----
// ----------------------------------------------------------------------------
// obes_ctrl
// Sequencer: bin loading, threshold product, window widening and result.
// ----------------------------------------------------------------------------
`default_nettype none

module obes_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic             i_last_bin,
    output obes_pkg::t_dp_cmd     o_cmd,
    input  obes_pkg::t_dp_sts     i_sts,
    output logic                  o_busy,
    output logic                  o_valid
);
    import obes_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start && i_last_bin) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:   n_state = ST_PROD;
            ST_PROD: begin
                if (i_sts.prod_done) begin
                    n_state = ST_CTR_RD;
                end
            end
            ST_CTR_RD:  n_state = ST_CTR_ADD;
            ST_CTR_ADD: n_state = ST_STEP_RD;
            ST_STEP_RD: n_state = ST_ADD_LO;
            ST_ADD_LO:  n_state = ST_ADD_HI;
            ST_ADD_HI:  n_state = ST_SCALE;
            ST_SCALE:   n_state = ST_CMP;
            ST_CMP: begin
                if (i_sts.hit || i_sts.at_edge) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_STEP_RD;
                end
            end
            ST_OUT:     n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            ST_DRAIN:   o_cmd.init    = 1'b1;
            ST_PROD:    o_cmd.prod    = 1'b1;
            ST_CTR_RD:  o_cmd.rd_ctr  = 1'b1;
            ST_CTR_ADD: o_cmd.add_hi  = 1'b1;  // carrier bin sits on the high port
            ST_STEP_RD: o_cmd.rd_step = 1'b1;
            ST_ADD_LO:  o_cmd.add_lo  = 1'b1;
            ST_ADD_HI:  o_cmd.add_hi  = 1'b1;
            ST_SCALE:   o_cmd.scale   = 1'b1;
            ST_CMP:     o_cmd.cmp     = 1'b1;
            ST_OUT: begin
                o_valid     = 1'b1;
                o_cmd.clear = 1'b1;
            end
            default:    o_busy = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/obes_dp.sv -----
// ----------------------------------------------------------------------------
// obes_dp
// Datapath: squaring, energy store, accumulators and window search unit.
// ----------------------------------------------------------------------------
`default_nettype none

module obes_dp #(
    parameter int MAX_BINS  = obes_pkg::DEF_MAX_BINS,
    parameter int MAG_WIDTH = obes_pkg::DEF_MAG_WIDTH,
    localparam int CNT_W    = $clog2(MAX_BINS + 1),
    localparam int SUM_W    = 2 * MAG_WIDTH + CNT_W
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  obes_pkg::t_dp_cmd                   i_cmd,
    output obes_pkg::t_dp_sts                   o_sts,
    input  wire logic [MAG_WIDTH-1:0]           i_mag,
    input  wire logic [obes_pkg::CARRIER_W-1:0] i_carrier,
    input  wire logic [obes_pkg::THRESH_W-1:0]  i_thresh,
    output logic [CNT_W-1:0]                    o_half,
    output logic [SUM_W-1:0]                    o_window,
    output logic [SUM_W-1:0]                    o_total,
    output logic                                o_edge
);
    import obes_pkg::*;

    localparam int AW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int SQ_W  = 2 * MAG_WIDTH;
    localparam int CMP_W = SUM_W + THRESH_W;
    localparam int PW    = ((CNT_W > CARRIER_W) ? CNT_W : CARRIER_W) + 1;
    localparam int BIT_W = $clog2(THRESH_W);

    logic [SQ_W-1:0]  mem [MAX_BINS];

    logic [CNT_W-1:0] r_cnt;
    logic [SQ_W-1:0]  r_sq;
    logic             r_sq_vld;
    logic [AW-1:0]    r_sq_addr;
    logic [SUM_W-1:0] r_total;

    logic [CMP_W-1:0] r_prod;
    logic [BIT_W-1:0] r_bit;
    logic [CNT_W-1:0] r_a;
    logic [SUM_W-1:0] r_w;
    logic [CMP_W-1:0] r_w100;
    logic [SQ_W-1:0]  r_rd_lo;
    logic [SQ_W-1:0]  r_rd_hi;
    logic             r_lo_ok;
    logic             r_hi_ok;
    logic             r_edge;

    logic             room;
    logic [CNT_W-1:0] a_next;
    logic [PW-1:0]    c_ext;
    logic [PW-1:0]    n_ext;
    logic [PW-1:0]    an_ext;
    logic [PW-1:0]    lo_pos;
    logic [PW-1:0]    hi_pos;
    logic [AW-1:0]    addr_lo;
    logic [AW-1:0]    addr_hi;
    logic [CMP_W-1:0] w_ext;
    logic             hit;
    logic             at_edge;

    assign room   = (r_cnt < CNT_W'(MAX_BINS));
    assign a_next = r_a + 1'b1;
    assign c_ext  = PW'(i_carrier);
    assign n_ext  = PW'(r_cnt);
    assign an_ext = PW'(a_next);
    assign lo_pos = c_ext - an_ext;
    assign hi_pos = i_cmd.rd_ctr ? c_ext : (c_ext + an_ext);
    assign addr_lo = lo_pos[AW-1:0];
    assign addr_hi = hi_pos[AW-1:0];
    assign w_ext  = CMP_W'(r_w);

    assign hit     = (r_w100 > r_prod);
    assign at_edge = ((c_ext + PW'(r_a) + 1'b1) >= n_ext);

    assign o_sts.prod_done = (r_bit == '0);
    assign o_sts.hit       = hit;
    assign o_sts.at_edge   = at_edge;

    // load stage 1: square, reserve a slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_sq_vld <= 1'b0;
        end else begin
            r_sq_vld <= i_cmd.load && room;
            if (i_cmd.clear) begin
                r_cnt <= '0;
            end else if (i_cmd.load && room) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq      <= SQ_W'(i_mag) * SQ_W'(i_mag);
        r_sq_addr <= r_cnt[AW-1:0];
    end

    // load stage 2: store and accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cmd.clear) begin
            r_total <= '0;
        end else if (r_sq_vld) begin
            r_total <= r_total + SUM_W'(r_sq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sq_vld) begin
            mem[r_sq_addr] <= r_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_ctr || i_cmd.rd_step) begin
            r_rd_lo <= mem[addr_lo];
            r_rd_hi <= mem[addr_hi];
        end
    end

    // threshold * total, MSB first, one bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_prod <= '0;
            r_bit  <= BIT_W'(THRESH_W - 1);
        end else if (i_cmd.prod) begin
            r_prod <= (r_prod << 1) + (i_thresh[r_bit] ? CMP_W'(r_total) : '0);
            r_bit  <= r_bit - 1'b1;
        end
    end

    // window search
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_a <= '0;
            r_w <= '0;
        end
        if (i_cmd.rd_ctr) begin
            r_lo_ok <= 1'b0;
            r_hi_ok <= (c_ext < n_ext);
        end
        if (i_cmd.rd_step) begin
            r_a     <= a_next;
            r_lo_ok <= (c_ext >= an_ext) && (lo_pos < n_ext);
            r_hi_ok <= (hi_pos < n_ext);
        end
        if (i_cmd.add_lo && r_lo_ok) begin
            r_w <= r_w + SUM_W'(r_rd_lo);
        end
        if (i_cmd.add_hi && r_hi_ok) begin
            r_w <= r_w + SUM_W'(r_rd_hi);
        end
        if (i_cmd.scale) begin
            // x100 = x64 + x32 + x4
            r_w100 <= (w_ext << 6) + (w_ext << 5) + (w_ext << 2);
        end
        if (i_cmd.cmp) begin
            r_edge <= !hit && at_edge;
        end
    end

    assign o_half   = r_a;
    assign o_window = r_w;
    assign o_total  = r_total;
    assign o_edge   = r_edge;

endmodule

`default_nettype wire

// ----- hdl/occupied_bandwidth_energy_search.sv -----
// ----------------------------------------------------------------------------
// occupied_bandwidth_energy_search
// Squares and stores spectrum bins, then widens a window around the carrier
// until its energy share passes the threshold or the spectrum edge is hit.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  bins     | start, busy, i_bin_magnitude, i_last_bin  | in (busy: out)
//  result   | o_valid, o_half_width, o_bandwidth_bins,  | out
//           | o_window_energy, o_total_energy,          |
//           | o_reached_edge                            |
//  config   | i_cfg_we, i_cfg_idx, i_cfg_wdata          | in
//
// Bins load one per cycle while busy is low. After the last bin, busy stays
// high while the last bin is committed, threshold * total is formed one bit
// at a time, the carrier bin is added and the window widens step by step
// (registered store read, both edges through the single shared adder, scale
// and compare). o_valid pulses for one cycle; the receiver cannot stall.
// Synchronous active-low reset; the energy store itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module occupied_bandwidth_energy_search #(
    parameter int MAX_BINS  = obes_pkg::DEF_MAX_BINS,
    parameter int MAG_WIDTH = obes_pkg::DEF_MAG_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [MAG_WIDTH-1:0]            i_bin_magnitude,
    input  wire logic                            i_last_bin,
    input  wire logic                            i_cfg_we,
    input  wire logic [obes_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [obes_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                                 o_valid,
    output logic [obes_pkg::HALF_W-1:0]          o_half_width,
    output logic [obes_pkg::BW_W-1:0]            o_bandwidth_bins,
    output logic [obes_pkg::ENERGY_W-1:0]        o_window_energy,
    output logic [obes_pkg::ENERGY_W-1:0]        o_total_energy,
    output logic                                 o_reached_edge
);
    import obes_pkg::*;

    localparam int CNT_W = $clog2(MAX_BINS + 1);
    localparam int SUM_W = 2 * MAG_WIDTH + CNT_W;

    logic [CARRIER_W-1:0] r_carrier;
    logic [THRESH_W-1:0]  r_thresh;

    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic [CNT_W-1:0] half;
    logic [SUM_W-1:0] window;
    logic [SUM_W-1:0] total;
    logic             edge_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier <= CARRIER_RST;
            r_thresh  <= THRESH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CARRIER: r_carrier <= i_cfg_wdata[CARRIER_W-1:0];
                REG_THRESH:  r_thresh  <= i_cfg_wdata[THRESH_W-1:0];
                default:     r_carrier <= r_carrier;
            endcase
        end
    end

    obes_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_last_bin (i_last_bin),
        .o_cmd      (cmd),
        .i_sts      (sts),
        .o_busy     (busy),
        .o_valid    (o_valid)
    );

    obes_dp #(
        .MAX_BINS  (MAX_BINS),
        .MAG_WIDTH (MAG_WIDTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_mag     (i_bin_magnitude),
        .i_carrier (r_carrier),
        .i_thresh  (r_thresh),
        .o_half    (half),
        .o_window  (window),
        .o_total   (total),
        .o_edge    (edge_hit)
    );

    assign o_half_width     = HALF_W'(half);
    assign o_bandwidth_bins = BW_W'(half) << 1;
    assign o_window_energy  = ENERGY_W'(window);
    assign o_total_energy   = ENERGY_W'(total);
    assign o_reached_edge   = edge_hit;

endmodule

`default_nettype wire
